@@ hdl/spmd_pkg.sv @@
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared widths, types and codes for the 3D segment pair distance pipeline.
// ----------------------------------------------------------------------------
package spmd_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 16;

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DOT_W    = PROD_W + 2;
    localparam int WIDE_W   = 2 * DOT_W + 1;
    localparam int PARAM_W  = FRAC_BITS + 1;
    localparam int DF_W     = FRAC_BITS + DIFF_W + 3;
    localparam int SQ_W     = 2 * DF_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int DIST_W   = 50;
    localparam int DIV_LAT  = FRAC_BITS + 1;
    localparam int PIPE_DEPTH = 13 + 3 * DIV_LAT;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [DOT_W-1:0]       t_dot;
    typedef logic signed [WIDE_W-1:0]      t_wide;
    typedef logic        [PARAM_W-1:0]     t_param;
    typedef logic signed [DF_W-1:0]        t_df;
    typedef logic signed [SQ_W-1:0]        t_sq;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic        [DIST_W-1:0]      t_dist;

    localparam t_param ONE_FIX = t_param'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        CASE_GENERAL     = 3'd0,
        CASE_A_POINT     = 3'd1,
        CASE_B_POINT     = 3'd2,
        CASE_BOTH_POINTS = 3'd3,
        CASE_PARALLEL    = 3'd4
    } t_case;

    typedef struct packed {
        t_diff [2:0] d1;
        t_diff [2:0] d2;
        t_diff [2:0] rv;
        t_dot        dd1;
        t_dot        dd2;
        t_dot        rr;
        t_dot        s1;
        t_dot        s2;
        t_case       code;
        logic        clampu;
        t_param      fixu;
        t_param      uu;
    } t_ctx;

endpackage

@@ hdl/spmd_if.sv @@
// ----------------------------------------------------------------------------
// spmd_in_if / spmd_out_if
// Valid/ready channels carrying a segment pair item and a distance item.
// ----------------------------------------------------------------------------
interface spmd_in_if;
    import spmd_pkg::*;
    logic   valid;
    logic   ready;
    t_coord a_start_x;
    t_coord a_start_y;
    t_coord a_start_z;
    t_coord a_end_x;
    t_coord a_end_y;
    t_coord a_end_z;
    t_coord b_start_x;
    t_coord b_start_y;
    t_coord b_start_z;
    t_coord b_end_x;
    t_coord b_end_y;
    t_coord b_end_z;

    modport source (output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
                    a_end_z, b_start_x, b_start_y, b_start_z, b_end_x, b_end_y,
                    b_end_z, input ready);
    modport sink (input valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
                  a_end_z, b_start_x, b_start_y, b_start_z, b_end_x, b_end_y,
                  b_end_z, output ready);
endinterface

interface spmd_out_if;
    import spmd_pkg::*;
    logic   valid;
    logic   ready;
    t_dist  dist_squared;
    t_param param_first;
    t_param param_second;
    t_case  case_code;

    modport source (output valid, dist_squared, param_first, param_second, case_code,
                    input ready);
    modport sink (input valid, dist_squared, param_first, param_second, case_code,
                  output ready);
endinterface

@@ hdl/spmd_div.sv @@
// ----------------------------------------------------------------------------
// spmd_div
// Pipelined fraction divider: clamp(trunc(num/den * 2^FRAC_BITS)) to [0, 1],
// one quotient bit per stage, den > 0.
// ----------------------------------------------------------------------------
module spmd_div (
    input  logic            i_clk,
    input  logic            i_en,
    input  spmd_pkg::t_wide i_num,
    input  spmd_pkg::t_wide i_den,
    output spmd_pkg::t_param o_q
);
    import spmd_pkg::*;

    typedef logic [WIDE_W-1:0] t_rem;

    t_rem                 r_rem  [DIV_LAT];
    t_rem                 r_den  [DIV_LAT];
    logic [FRAC_BITS-1:0] r_q    [DIV_LAT];
    logic                 r_zero [DIV_LAT];
    logic                 r_one  [DIV_LAT];

    t_rem                 n_rem [1:FRAC_BITS];
    logic [FRAC_BITS-1:0] n_q   [1:FRAC_BITS];

    always_comb begin
        t_rem sh;
        logic ge;
        for (int k = 1; k < DIV_LAT; k++) begin
            sh       = {r_rem[k-1][WIDE_W-2:0], 1'b0};
            ge       = (sh >= r_den[k-1]);
            n_rem[k] = ge ? (sh - r_den[k-1]) : sh;
            n_q[k]   = {r_q[k-1][FRAC_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_num[WIDE_W-1] || (i_num == '0);
            r_one[0]  <= !i_num[WIDE_W-1] && (i_num != '0) && (i_num >= i_den);
            r_rem[0]  <= t_rem'(i_num);
            r_den[0]  <= t_rem'(i_den);
            r_q[0]    <= '0;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_one[k]  <= r_one[k-1];
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= n_q[k];
            end
        end
    end

    assign o_q = r_zero[DIV_LAT-1] ? '0 :
                 r_one[DIV_LAT-1]  ? ONE_FIX : {1'b0, r_q[DIV_LAT-1]};

endmodule

@@ hdl/segment_pair_min_distance_3d.sv @@
// ----------------------------------------------------------------------------
// segment_pair_min_distance_3d
// Squared minimum distance and clamped parameters of two 3D segments.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock and returns one result per pair, in order.
// The three chained divisions (t, then u, then t again) each run through a
// divider with one quotient bit per stage, and they set the depth. When the
// output is held, the whole pipeline holds with it; input ready is high when
// the output register is empty or its result is taken.
module segment_pair_min_distance_3d (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spmd_in_if.sink      i_seg,
    spmd_out_if.source   o_res
);
    import spmd_pkg::*;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign adv         = !r_vld[PIPE_DEPTH-1] || o_res.ready;
    assign i_seg.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_seg.valid};
        end
    end

    // stage 1: differences
    t_ctx n1_c, r1_c;
    always_comb begin
        n1_c = '0;
        n1_c.d1[0] = t_diff'(i_seg.a_end_x) - t_diff'(i_seg.a_start_x);
        n1_c.d1[1] = t_diff'(i_seg.a_end_y) - t_diff'(i_seg.a_start_y);
        n1_c.d1[2] = t_diff'(i_seg.a_end_z) - t_diff'(i_seg.a_start_z);
        n1_c.d2[0] = t_diff'(i_seg.b_end_x) - t_diff'(i_seg.b_start_x);
        n1_c.d2[1] = t_diff'(i_seg.b_end_y) - t_diff'(i_seg.b_start_y);
        n1_c.d2[2] = t_diff'(i_seg.b_end_z) - t_diff'(i_seg.b_start_z);
        n1_c.rv[0] = t_diff'(i_seg.b_start_x) - t_diff'(i_seg.a_start_x);
        n1_c.rv[1] = t_diff'(i_seg.b_start_y) - t_diff'(i_seg.a_start_y);
        n1_c.rv[2] = t_diff'(i_seg.b_start_z) - t_diff'(i_seg.a_start_z);
    end

    always_ff @(posedge i_clk) begin
        if (adv) r1_c <= n1_c;
    end

    // stage 2: element products
    t_ctx  r2_c;
    t_prod r2_p11 [3];
    t_prod r2_p22 [3];
    t_prod r2_p12 [3];
    t_prod r2_p1r [3];
    t_prod r2_p2r [3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_c <= r1_c;
            for (int k = 0; k < 3; k++) begin
                r2_p11[k] <= $signed(r1_c.d1[k]) * $signed(r1_c.d1[k]);
                r2_p22[k] <= $signed(r1_c.d2[k]) * $signed(r1_c.d2[k]);
                r2_p12[k] <= $signed(r1_c.d1[k]) * $signed(r1_c.d2[k]);
                r2_p1r[k] <= $signed(r1_c.d1[k]) * $signed(r1_c.rv[k]);
                r2_p2r[k] <= $signed(r1_c.d2[k]) * $signed(r1_c.rv[k]);
            end
        end
    end

    // stage 3: dot products
    t_ctx n3_c, r3_c;
    always_comb begin
        n3_c     = r2_c;
        n3_c.dd1 = t_dot'(r2_p11[0]) + t_dot'(r2_p11[1]) + t_dot'(r2_p11[2]);
        n3_c.dd2 = t_dot'(r2_p22[0]) + t_dot'(r2_p22[1]) + t_dot'(r2_p22[2]);
        n3_c.rr  = t_dot'(r2_p12[0]) + t_dot'(r2_p12[1]) + t_dot'(r2_p12[2]);
        n3_c.s1  = t_dot'(r2_p1r[0]) + t_dot'(r2_p1r[1]) + t_dot'(r2_p1r[2]);
        n3_c.s2  = t_dot'(r2_p2r[0]) + t_dot'(r2_p2r[1]) + t_dot'(r2_p2r[2]);
    end

    always_ff @(posedge i_clk) begin
        if (adv) r3_c <= n3_c;
    end

    // stage 4: cross products
    t_ctx  r4_c;
    t_wide r4_mdd, r4_mrr, r4_msd, r4_msr;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_c   <= r3_c;
            r4_mdd <= $signed(r3_c.dd1) * $signed(r3_c.dd2);
            r4_mrr <= $signed(r3_c.rr) * $signed(r3_c.rr);
            r4_msd <= $signed(r3_c.s1) * $signed(r3_c.dd2);
            r4_msr <= $signed(r3_c.s2) * $signed(r3_c.rr);
        end
    end

    // stage 5: case selection, first division operands
    t_ctx  n5_c, r5_c;
    t_wide n5_den, n5_num, n5_sum, r5_num, r5_den;
    logic  n5_z1, n5_z2, n5_s2pos;

    always_comb begin
        n5_c     = r4_c;
        n5_den   = r4_mdd - r4_mrr;
        n5_num   = r4_msd - r4_msr;
        n5_z1    = (r4_c.dd1 == '0);
        n5_z2    = (r4_c.dd2 == '0);
        n5_s2pos = !r4_c.s2[DOT_W-1] && (r4_c.s2 != '0);
        n5_sum   = t_wide'($signed(r4_c.s2)) + t_wide'($signed(r4_c.dd2));
        if (n5_z1 && !n5_z2) begin
            n5_c.code = CASE_A_POINT;
        end else if (n5_z2 && !n5_z1) begin
            n5_c.code = CASE_B_POINT;
        end else if (n5_z1 && n5_z2) begin
            n5_c.code = CASE_BOTH_POINTS;
        end else if (n5_den == '0) begin
            n5_c.code = CASE_PARALLEL;
        end else begin
            n5_c.code = CASE_GENERAL;
        end
        n5_c.clampu = (n5_c.code == CASE_PARALLEL) && (n5_s2pos || n5_sum[WIDE_W-1]);
        n5_c.fixu   = n5_s2pos ? '0 : ONE_FIX;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_c   <= n5_c;
            r5_num <= n5_num;
            r5_den <= n5_den;
        end
    end

    // division 1: t from the full system
    t_param q1, q2, q3;
    t_ctx   r_d1c [DIV_LAT];
    t_ctx   r_d2c [DIV_LAT];
    t_ctx   r_d3c [DIV_LAT];

    spmd_div u_div1 (.i_clk(i_clk), .i_en(adv), .i_num(r5_num), .i_den(r5_den), .o_q(q1));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1c[0] <= r5_c;
            for (int k = 1; k < DIV_LAT; k++) r_d1c[k] <= r_d1c[k-1];
        end
    end

    // stages 6, 7: u numerator
    t_ctx   c6, r6_c, r7_c;
    t_param n6_f;
    t_wide  r6_prod, r7_num, r7_den;

    assign c6   = r_d1c[DIV_LAT-1];
    assign n6_f = (c6.code == CASE_GENERAL) ? q1 : '0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_c    <= c6;
            r6_prod <= $signed({1'b0, n6_f}) * $signed(c6.rr);
            r7_c    <= r6_c;
            r7_num  <= r6_prod - (t_wide'($signed(r6_c.s2)) <<< FRAC_BITS);
            r7_den  <= t_wide'($signed(r6_c.dd2)) <<< FRAC_BITS;
        end
    end

    spmd_div u_div2 (.i_clk(i_clk), .i_en(adv), .i_num(r7_num), .i_den(r7_den), .o_q(q2));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d2c[0] <= r7_c;
            for (int k = 1; k < DIV_LAT; k++) r_d2c[k] <= r_d2c[k-1];
        end
    end

    // stages 8, 9: u select, t numerator
    t_ctx   c8, n8_c, r8_c, r9_c;
    t_wide  r8_prod, r9_num, r9_den;

    assign c8 = r_d2c[DIV_LAT-1];

    always_comb begin
        n8_c = c8;
        if (c8.clampu) begin
            n8_c.uu = c8.fixu;
        end else if (c8.code == CASE_GENERAL || c8.code == CASE_A_POINT ||
                     c8.code == CASE_PARALLEL) begin
            n8_c.uu = q2;
        end else begin
            n8_c.uu = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_c    <= n8_c;
            r8_prod <= $signed({1'b0, n8_c.uu}) * $signed(c8.rr);
            r9_c    <= r8_c;
            r9_num  <= r8_prod + (t_wide'($signed(r8_c.s1)) <<< FRAC_BITS);
            r9_den  <= t_wide'($signed(r8_c.dd1)) <<< FRAC_BITS;
        end
    end

    spmd_div u_div3 (.i_clk(i_clk), .i_en(adv), .i_num(r9_num), .i_den(r9_den), .o_q(q3));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d3c[0] <= r9_c;
            for (int k = 1; k < DIV_LAT; k++) r_d3c[k] <= r_d3c[k-1];
        end
    end

    // stages 10 to 13: closest point difference and squared distance
    t_ctx   c10, r10_c;
    t_param n10_t, r10_t, r11_t, r12_t;
    t_param r11_u, r12_u;
    t_case  r11_code, r12_code;
    t_df    r10_td [3];
    t_df    r10_ud [3];
    t_df    r11_df [3];
    t_sq    r12_sq [3];
    t_sum   n13_sum;

    t_dist  r_dist;
    t_param r_tp, r_up;
    t_case  r_code;

    assign c10   = r_d3c[DIV_LAT-1];
    assign n10_t = (c10.code == CASE_GENERAL || c10.code == CASE_B_POINT || c10.clampu) ?
                   q3 : '0;

    assign n13_sum = t_sum'(r12_sq[0]) + t_sum'(r12_sq[1]) + t_sum'(r12_sq[2]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r10_c <= c10;
            r10_t <= n10_t;
            for (int k = 0; k < 3; k++) begin
                r10_td[k] <= $signed({1'b0, n10_t}) * $signed(c10.d1[k]);
                r10_ud[k] <= $signed({1'b0, c10.uu}) * $signed(c10.d2[k]);
                r11_df[k] <= r10_td[k] - r10_ud[k] -
                             (t_df'($signed(r10_c.rv[k])) <<< FRAC_BITS);
                r12_sq[k] <= r11_df[k] * r11_df[k];
            end
            r11_t    <= r10_t;
            r11_u    <= r10_c.uu;
            r11_code <= r10_c.code;
            r12_t    <= r11_t;
            r12_u    <= r11_u;
            r12_code <= r11_code;
            r_dist   <= DIST_W'(n13_sum >> FRAC_BITS);
            r_tp     <= r12_t;
            r_up     <= r12_u;
            r_code   <= r12_code;
        end
    end

    assign o_res.valid        = r_vld[PIPE_DEPTH-1];
    assign o_res.dist_squared = r_dist;
    assign o_res.param_first  = r_tp;
    assign o_res.param_second = r_up;
    assign o_res.case_code    = r_code;

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH-1] && !o_res.ready |-> !i_seg.ready)
        else $error("input taken while output stalled");

    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH-1] |-> (r_tp <= ONE_FIX) && (r_up <= ONE_FIX))
        else $error("parameter above one");

    a_both_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH-1] && r_code == CASE_BOTH_POINTS |-> r_tp == '0 && r_up == '0)
        else $error("nonzero parameter for two points");

    a_a_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH-1] && r_code == CASE_A_POINT |-> r_tp == '0)
        else $error("nonzero first parameter for point segment");
`endif

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for segment_pair_min_distance_3d: drives segment pairs with random
// idling, predicts each result with a 128-bit fixed-point model of the
// clamped closest-point search, and checks results in order field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import spmd_pkg::*;

    typedef struct {
        logic signed [15:0] c[12];
    } t_pair;

    typedef struct {
        t_dist  dsq;
        t_param pf;
        t_param ps;
        t_case  code;
    } t_dist_res;

    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   errors = 0;
    bit   quiet = 0;
    int   hold_off = 0;

    t_dist_res dist_expected[$];

    spmd_in_if  seg_if();
    spmd_out_if res_if();

    segment_pair_min_distance_3d u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_if.sink),
        .o_res  (res_if.source)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint frac_quot(logic signed [127:0] num, logic signed [127:0] den);
        logic signed [127:0] n;
        longint q;
        n = num;
        q = 0;
        if (n <= 0) return 0;
        if (n >= den) return 64'd65536;
        for (int i = 0; i < FRAC_BITS; i++) begin
            n = n <<< 1;
            q = q << 1;
            if (n >= den) begin
                n = n - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint clamp_step(longint f, longint rr, longint s, longint d);
        logic signed [127:0] num;
        logic signed [127:0] den;
        num = 128'(f) * 128'(rr) + (128'(s) <<< FRAC_BITS);
        den = 128'(d) <<< FRAC_BITS;
        return frac_quot(num, den);
    endfunction

    function automatic t_dist_res predict_distance(t_pair p);
        longint as[3], bs[3], d1[3], d2[3], r[3];
        longint dd1, dd2, rr, s1, s2, t, u, c1, c2, df;
        logic signed [127:0] den, acc;
        t_dist_res res;
        t = 0;
        u = 0;
        for (int k = 0; k < 3; k++) begin
            as[k] = p.c[k];
            bs[k] = p.c[6+k];
            d1[k] = longint'(p.c[3+k]) - as[k];
            d2[k] = longint'(p.c[9+k]) - bs[k];
            r[k]  = bs[k] - as[k];
        end
        dd1 = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
        dd2 = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
        rr  = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
        s1  = d1[0]*r[0] + d1[1]*r[1] + d1[2]*r[2];
        s2  = d2[0]*r[0] + d2[1]*r[1] + d2[2]*r[2];
        den = 128'(dd1) * 128'(dd2) - 128'(rr) * 128'(rr);
        if (dd1 == 0 && dd2 > 0) begin
            res.code = CASE_A_POINT;
            u = frac_quot(128'(-s2), 128'(dd2));
        end else if (dd2 == 0 && dd1 > 0) begin
            res.code = CASE_B_POINT;
            t = frac_quot(128'(s1), 128'(dd1));
        end else if (dd1 == 0 && dd2 == 0) begin
            res.code = CASE_BOTH_POINTS;
        end else if (den == 0) begin
            res.code = CASE_PARALLEL;
            if (s2 > 0 || -s2 > dd2) begin
                u = (s2 > 0) ? 0 : 65536;
                t = clamp_step(u, rr, s1, dd1);
            end else begin
                u = frac_quot(128'(-s2), 128'(dd2));
            end
        end else begin
            res.code = CASE_GENERAL;
            t = frac_quot(128'(s1) * 128'(dd2) - 128'(s2) * 128'(rr), den);
            u = clamp_step(t, rr, -s2, dd2);
            t = clamp_step(u, rr, s1, dd1);
        end
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            c1 = as[k] * 65536 + t * d1[k];
            c2 = bs[k] * 65536 + u * d2[k];
            df = c1 - c2;
            acc = acc + 128'(df) * 128'(df);
        end
        acc = acc >>> FRAC_BITS;
        res.dsq = acc[DIST_W-1:0];
        res.pf = t[PARAM_W-1:0];
        res.ps = u[PARAM_W-1:0];
        return res;
    endfunction

    task automatic idle_burst();
        repeat ($urandom_range(1, 16)) @(negedge i_clk);
    endtask

    task automatic send_pair(t_pair p);
        seg_if.valid     <= 1'b1;
        seg_if.a_start_x <= p.c[0];
        seg_if.a_start_y <= p.c[1];
        seg_if.a_start_z <= p.c[2];
        seg_if.a_end_x   <= p.c[3];
        seg_if.a_end_y   <= p.c[4];
        seg_if.a_end_z   <= p.c[5];
        seg_if.b_start_x <= p.c[6];
        seg_if.b_start_y <= p.c[7];
        seg_if.b_start_z <= p.c[8];
        seg_if.b_end_x   <= p.c[9];
        seg_if.b_end_y   <= p.c[10];
        seg_if.b_end_z   <= p.c[11];
        do @(posedge i_clk); while (!seg_if.ready);
        dist_expected.push_back(predict_distance(p));
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            seg_if.valid <= 1'b0;
            idle_burst();
        end
    endtask

    task automatic wait_drained();
        seg_if.valid <= 1'b0;
        while (dist_expected.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_pair rand_pair(int span);
        t_pair p;
        for (int i = 0; i < 12; i++) begin
            if (span >= 32768) p.c[i] = 16'($urandom);
            else p.c[i] = 16'($urandom_range(0, 2 * span) - span);
        end
        return p;
    endfunction

    function automatic t_pair fill_pair(int v0, int v1, int v2, int v3, int v4, int v5,
                                        int v6, int v7, int v8, int v9, int v10, int v11);
        t_pair p;
        p.c = '{16'(v0), 16'(v1), 16'(v2), 16'(v3), 16'(v4), 16'(v5),
                16'(v6), 16'(v7), 16'(v8), 16'(v9), 16'(v10), 16'(v11)};
        return p;
    endfunction

    task automatic test_directed();
        send_pair(fill_pair(0, 0, 0, 10, 0, 0, 0, 5, 5, 10, 5, 5));
        send_pair(fill_pair(3, 3, 3, 3, 3, 3, 0, 0, 0, 8, 1, -2));
        send_pair(fill_pair(-4, 1, 9, 7, 7, -3, 2, 2, 2, 2, 2, 2));
        send_pair(fill_pair(1, 2, 3, 1, 2, 3, -5, 6, -7, -5, 6, -7));
        send_pair(fill_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(fill_pair(0, 0, 0, 10, 0, 0, 2, 1, 0, 6, 1, 0));
        send_pair(fill_pair(0, 0, 0, 10, 0, 0, 20, 3, 0, 30, 3, 0));
        send_pair(fill_pair(0, 0, 0, 10, 0, 0, -30, 3, 0, -20, 3, 0));
        send_pair(fill_pair(0, 0, 0, 10, 0, 0, 14, 3, 0, 4, 3, 0));
        send_pair(fill_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                            32767, -32768, 32767, -32768, 32767, -32768));
        send_pair(fill_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                            32767, 32767, 32767, -32768, -32768, -32768));
        send_pair(fill_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                            32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(fill_pair(32767, 0, 0, -32768, 0, 0, 0, 32767, 0, 0, -32768, 0));
        send_pair(fill_pair(-32768, 32767, -32768, 32767, -32768, 32767,
                            -32768, -32768, -32768, 32767, 32767, 32767));
        send_pair(fill_pair(0, 0, 0, 1, 0, 0, 100, 100, 100, 101, 101, 101));
        send_pair(fill_pair(0, 0, 0, 1, 1, 1, 5, 5, 5, 7, 7, 7));
        send_pair(fill_pair(0, 0, 0, 2, 4, 6, 1, 2, 3, -1, -2, -3));
        send_pair(fill_pair(-1, -1, -1, 0, 0, 0, 0, 0, 0, -1, -1, -1));
    endtask

    task automatic test_random(int count);
        t_pair p;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: p = rand_pair(32768);
                1, 2: p = rand_pair(20);
                3: begin
                    p = rand_pair(300);
                    for (int k = 0; k < 3; k++) p.c[3+k] = p.c[k];
                end
                4: begin
                    p = rand_pair(300);
                    for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k];
                end
                5: begin
                    p = rand_pair(8);
                    for (int k = 0; k < 3; k++) begin
                        p.c[9+k] = p.c[6+k] + (p.c[3+k] - p.c[k]) * $urandom_range(1, 3);
                        if ($urandom_range(0, 1)) p.c[9+k] = p.c[6+k] - (p.c[3+k] - p.c[k]);
                    end
                end
                6: begin
                    p = rand_pair(32768);
                    for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k] + p.c[3+k] - p.c[k];
                end
                default: p = rand_pair(2000);
            endcase
            send_pair(p);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        test_random(120);
        wait_drained();
    endtask

    task automatic test_flat_out(int count);
        quiet = 1;
        test_random(count);
        wait_drained();
    endtask

    initial begin
        seg_if.valid = 1'b0;
        {seg_if.a_start_x, seg_if.a_start_y, seg_if.a_start_z, seg_if.a_end_x,
         seg_if.a_end_y, seg_if.a_end_z, seg_if.b_start_x, seg_if.b_start_y,
         seg_if.b_start_z, seg_if.b_end_x, seg_if.b_end_y, seg_if.b_end_z} = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        wait_drained();
        test_random(500);
        wait_drained();
        test_backpressure();
        test_flat_out(280);
        repeat (PIPE_DEPTH + 20) @(negedge i_clk);
        if (errors == 0 && dist_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        res_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_off > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_off) @(negedge i_clk);
                hold_off = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                idle_burst();
            end else begin
                res_if.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_dist_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (dist_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected result dist=%0d", $time, res_if.dist_squared);
            end else begin
                e = dist_expected.pop_front();
                if (res_if.dist_squared !== e.dsq) begin
                    errors++;
                    $display("%0t: dist_squared expected %0d actual %0d",
                             $time, e.dsq, res_if.dist_squared);
                end
                if (res_if.param_first !== e.pf) begin
                    errors++;
                    $display("%0t: param_first expected %0d actual %0d",
                             $time, e.pf, res_if.param_first);
                end
                if (res_if.param_second !== e.ps) begin
                    errors++;
                    $display("%0t: param_second expected %0d actual %0d",
                             $time, e.ps, res_if.param_second);
                end
                if (res_if.case_code !== e.code) begin
                    errors++;
                    $display("%0t: case_code expected %0d actual %0d",
                             $time, e.code, res_if.case_code);
                end
            end
        end
    end

endmodule
